FILE: src/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared widths, latencies and types for the spectral bin morph pipeline.
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int SQ_W         = 2 * SAMPLE_WIDTH;       // sum of two squares
  localparam int Q_W          = SAMPLE_WIDTH + 1;       // scaled component
  localparam int NUM_W        = 2 * SAMPLE_WIDTH + 1;   // dividend
  localparam int POS_W        = 17;
  localparam int BLEND_W      = SAMPLE_WIDTH + POS_W;

  localparam int SQRT_LAT     = SAMPLE_WIDTH + 1;
  localparam int DIV_LAT      = Q_W;
  localparam int TOTAL_LAT    = 3 + SQRT_LAT + 4 + DIV_LAT + 1;

  localparam logic [POS_W-1:0] POS_ONE  = POS_W'(65536);
  localparam logic [POS_W-1:0] POS_HALF = POS_W'(32768);

  typedef logic [SAMPLE_WIDTH-1:0] umag_t;

  // operand magnitudes and signs traveling beside the root units
  typedef struct packed {
    logic  ar_neg;
    logic  ai_neg;
    logic  br_neg;
    logic  bi_neg;
    umag_t ar;
    umag_t ai;
    umag_t br;
    umag_t bi;
    logic  last;
  } side_root_t;

  // signs and flags traveling beside the dividers
  typedef struct packed {
    logic re_neg;
    logic im_neg;
    logic zero;
    logic last;
  } side_div_t;

endpackage

FILE: src/sbm_if.sv
// ----------------------------------------------------------------------------
// sbm channel interfaces
// Valid/ready channels for input bins, output bins and the position register.
// ----------------------------------------------------------------------------
interface sbm_in_if import sbm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SAMPLE_WIDTH-1:0] a_re;
  logic signed [SAMPLE_WIDTH-1:0] a_im;
  logic signed [SAMPLE_WIDTH-1:0] b_re;
  logic signed [SAMPLE_WIDTH-1:0] b_im;
  logic                     last_in;
  modport source (output valid, a_re, a_im, b_re, b_im, last_in, input ready);
  modport sink   (input valid, a_re, a_im, b_re, b_im, last_in, output ready);
endinterface

interface sbm_out_if import sbm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SAMPLE_WIDTH-1:0] out_re;
  logic signed [SAMPLE_WIDTH-1:0] out_im;
  logic                     last_out;
  modport source (output valid, out_re, out_im, last_out, input ready);
  modport sink   (input valid, out_re, out_im, last_out, output ready);
endinterface

interface sbm_cfg_if import sbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: src/sbm_sqrt.sv
// ----------------------------------------------------------------------------
// sbm_sqrt
// Pipelined rounded square root, one result bit per stage, then rounding.
// ----------------------------------------------------------------------------
module sbm_sqrt import sbm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   radicand,
  output umag_t             root
);

  logic [SQ_W-1:0] rem [0:SAMPLE_WIDTH];
  logic [SQ_W-1:0] rt  [0:SAMPLE_WIDTH];

  assign rem[0] = radicand;
  assign rt[0]  = '0;

  for (genvar k = 1; k <= SAMPLE_WIDTH; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 * k);
    logic [SQ_W-1:0] trial;
    assign trial = rt[k-1] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k-1] >= trial) begin
          rem[k] <= rem[k-1] - trial;
          rt[k]  <= (rt[k-1] >> 1) + BIT;
        end else begin
          rem[k] <= rem[k-1];
          rt[k]  <= rt[k-1] >> 1;
        end
      end
    end
  end

  // round up when the remainder exceeds the floor root
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem[SAMPLE_WIDTH] > rt[SAMPLE_WIDTH]) begin
        root <= rt[SAMPLE_WIDTH][SAMPLE_WIDTH-1:0] + 1'b1;
      end else begin
        root <= rt[SAMPLE_WIDTH][SAMPLE_WIDTH-1:0];
      end
    end
  end

endmodule

FILE: src/sbm_div.sv
// ----------------------------------------------------------------------------
// sbm_div
// Pipelined restoring divider, one quotient bit per stage.
// The quotient is known to fit Q_W bits.
// ----------------------------------------------------------------------------
module sbm_div import sbm_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  umag_t            den,
  output logic [Q_W-1:0]   quot
);

  umag_t          rem [0:Q_W];
  logic [Q_W-1:0] low [0:Q_W];
  logic [Q_W-1:0] q   [0:Q_W];
  umag_t          dd  [0:Q_W];

  assign rem[0] = num[NUM_W-1:Q_W];
  assign low[0] = num[Q_W-1:0];
  assign q[0]   = '0;
  assign dd[0]  = den;

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [SAMPLE_WIDTH:0] trial;
    logic                  ge;
    assign trial = {rem[k-1], low[k-1][Q_W-1]};
    assign ge    = trial >= {1'b0, dd[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? SAMPLE_WIDTH'(trial - {1'b0, dd[k-1]}) : trial[SAMPLE_WIDTH-1:0];
        low[k] <= low[k-1] << 1;
        q[k]   <= {q[k-1][Q_W-2:0], ge};
        dd[k]  <= dd[k-1];
      end
    end
  end

  assign quot = q[Q_W];

endmodule

FILE: src/spectral_bin_morph_top.sv
// ----------------------------------------------------------------------------
// spectral_bin_morph_top
// Morphs one bin of spectrum A with one of spectrum B: blended magnitude
// along the phase of the dominant bin.
//
//   channel  dir  width  contents
//   in_bin   in   97     a_re, a_im, b_re, b_im, last_in
//   out_bin  out  49     out_re, out_im, last_out
//   cfg      in   17     morph_position (Q1.16, clamped at 1.0)
//
// One bin per clock while the output is not stalled; the pipeline includes the 25-stage
// root and the 25-stage divider. Reset clears valid bits and the position.
// The whole pipeline stalls only while a result sits unaccepted at the
// output; bubbles keep flowing otherwise, and cfg is always ready.
// ----------------------------------------------------------------------------
module spectral_bin_morph_top import sbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sbm_in_if.sink     in_bin,
  sbm_out_if.source  out_bin,
  sbm_cfg_if.sink    cfg
);

  logic [POS_W-1:0] position;
  logic [POS_W-1:0] tc;
  logic             en;
  logic [TOTAL_LAT:1] v;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (cfg.valid) begin
      position <= cfg.data;
    end
  end
  assign tc = (position > POS_ONE) ? POS_ONE : position;

  assign en           = !v[TOTAL_LAT] || out_bin.ready;
  assign in_bin.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[TOTAL_LAT-1:1], in_bin.valid};
    end
  end

  // stage 1: sign and magnitude
  side_root_t s1, s2, s3;
  always_ff @(posedge clk) begin
    if (en) begin
      s1.ar_neg <= in_bin.a_re[SAMPLE_WIDTH-1];
      s1.ai_neg <= in_bin.a_im[SAMPLE_WIDTH-1];
      s1.br_neg <= in_bin.b_re[SAMPLE_WIDTH-1];
      s1.bi_neg <= in_bin.b_im[SAMPLE_WIDTH-1];
      s1.ar <= in_bin.a_re[SAMPLE_WIDTH-1] ? umag_t'(-in_bin.a_re) : umag_t'(in_bin.a_re);
      s1.ai <= in_bin.a_im[SAMPLE_WIDTH-1] ? umag_t'(-in_bin.a_im) : umag_t'(in_bin.a_im);
      s1.br <= in_bin.b_re[SAMPLE_WIDTH-1] ? umag_t'(-in_bin.b_re) : umag_t'(in_bin.b_re);
      s1.bi <= in_bin.b_im[SAMPLE_WIDTH-1] ? umag_t'(-in_bin.b_im) : umag_t'(in_bin.b_im);
      s1.last <= in_bin.last_in;
    end
  end

  // stage 2: squares
  logic [SQ_W-1:0] sq_ar, sq_ai, sq_br, sq_bi;
  always_ff @(posedge clk) begin
    if (en) begin
      sq_ar <= SQ_W'(s1.ar) * SQ_W'(s1.ar);
      sq_ai <= SQ_W'(s1.ai) * SQ_W'(s1.ai);
      sq_br <= SQ_W'(s1.br) * SQ_W'(s1.br);
      sq_bi <= SQ_W'(s1.bi) * SQ_W'(s1.bi);
      s2    <= s1;
    end
  end

  // stage 3: sums
  logic [SQ_W-1:0] sum_a, sum_b;
  always_ff @(posedge clk) begin
    if (en) begin
      sum_a <= sq_ar + sq_ai;
      sum_b <= sq_br + sq_bi;
      s3    <= s2;
    end
  end

  umag_t mag_a, mag_b;
  sbm_sqrt u_sqrt_a (.clk(clk), .en(en), .radicand(sum_a), .root(mag_a));
  sbm_sqrt u_sqrt_b (.clk(clk), .en(en), .radicand(sum_b), .root(mag_b));

  side_root_t sr [0:SQRT_LAT];
  assign sr[0] = s3;
  for (genvar k = 1; k <= SQRT_LAT; k++) begin : g_sr
    always_ff @(posedge clk) begin
      if (en) sr[k] <= sr[k-1];
    end
  end

  // stage A: blend products and source pick
  side_root_t      sa;
  logic            a_zero, b_zero, use_a;
  logic [BLEND_W-1:0] pa, pb;
  umag_t           cr, ci, refm, refm1, refm2;
  side_div_t       d1, d2, d3;
  assign sa     = sr[SQRT_LAT];
  assign a_zero = (sa.ar == '0) && (sa.ai == '0);
  assign b_zero = (sa.br == '0) && (sa.bi == '0);
  always_comb begin
    use_a = tc < POS_HALF;
    if (use_a ? a_zero : b_zero) use_a = !use_a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa        <= BLEND_W'(mag_a) * BLEND_W'(POS_ONE - tc);
      pb        <= BLEND_W'(mag_b) * BLEND_W'(tc);
      cr        <= use_a ? sa.ar : sa.br;
      ci        <= use_a ? sa.ai : sa.bi;
      refm      <= use_a ? mag_a : mag_b;
      d1.re_neg <= use_a ? sa.ar_neg : sa.br_neg;
      d1.im_neg <= use_a ? sa.ai_neg : sa.bi_neg;
      d1.zero   <= a_zero && b_zero;
      d1.last   <= sa.last;
    end
  end

  // stage B: blended magnitude
  umag_t mag;
  umag_t cr2, ci2;
  logic [BLEND_W:0] bsum;
  assign bsum = {1'b0, pa} + {1'b0, pb} + (BLEND_W+1)'(POS_HALF);
  always_ff @(posedge clk) begin
    if (en) begin
      mag   <= bsum[SAMPLE_WIDTH+15:16];
      cr2   <= cr;
      ci2   <= ci;
      refm1 <= refm;
      d2    <= d1;
    end
  end

  // stage C: component times magnitude
  logic [SQ_W-1:0] pr, pi;
  always_ff @(posedge clk) begin
    if (en) begin
      pr    <= SQ_W'(cr2) * SQ_W'(mag);
      pi    <= SQ_W'(ci2) * SQ_W'(mag);
      refm2 <= refm1;
      d3    <= d2;
    end
  end

  // stage D: add half the divisor for rounding
  logic [NUM_W-1:0] nr, ni;
  umag_t            den;
  side_div_t        d4;
  always_ff @(posedge clk) begin
    if (en) begin
      nr  <= NUM_W'(pr) + NUM_W'(refm2 >> 1);
      ni  <= NUM_W'(pi) + NUM_W'(refm2 >> 1);
      den <= refm2;
      d4  <= d3;
    end
  end

  logic [Q_W-1:0] qr, qi;
  sbm_div u_div_re (.clk(clk), .en(en), .num(nr), .den(den), .quot(qr));
  sbm_div u_div_im (.clk(clk), .en(en), .num(ni), .den(den), .quot(qi));

  side_div_t sd [0:DIV_LAT];
  assign sd[0] = d4;
  for (genvar k = 1; k <= DIV_LAT; k++) begin : g_sd
    always_ff @(posedge clk) begin
      if (en) sd[k] <= sd[k-1];
    end
  end

  function automatic umag_t sat_enc(logic neg, logic [Q_W-1:0] q);
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] m;
    lim = neg ? (Q_W'(1) << (SAMPLE_WIDTH - 1)) : ((Q_W'(1) << (SAMPLE_WIDTH - 1)) - 1'b1);
    m   = (q > lim) ? lim : q;
    return neg ? umag_t'(-m) : m[SAMPLE_WIDTH-1:0];
  endfunction

  side_div_t sf;
  assign sf = sd[DIV_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      out_bin.out_re   <= sf.zero ? '0 : sat_enc(sf.re_neg, qr);
      out_bin.out_im   <= sf.zero ? '0 : sat_enc(sf.im_neg, qi);
      out_bin.last_out <= sf.last;
    end
  end
  assign out_bin.valid = v[TOTAL_LAT];

  // ready drops only behind a held result
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_bin.ready |-> out_bin.valid && !out_bin.ready)
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_bin.valid)
    else $error("result valid right after reset");

  a_bubble: assert property (@(posedge clk) disable iff (rst)
    en && !v[TOTAL_LAT-1] |=> !out_bin.valid)
    else $error("result appeared from a bubble");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_bin.valid && in_bin.ready |=> v[1])
    else $error("accepted beat lost at pipeline entry");

endmodule
